// ===== hw/rtl/tlsjf_pkg.sv =====
`default_nettype none
package tlsjf_pkg;
   localparam int LevelDepthDefault = 32;
   localparam logic [15:0] SliceReset = 16'd20;
   localparam int EntryWidth = 48;

   typedef enum logic [1:0] {
      STATUS_RUN     = 2'd0,
      STATUS_ADDED   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_NOTHING = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] burst;
      logic [15:0] remaining;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic        served_level;
      logic [15:0] job_tag;
      logic [31:0] start_time;
      logic [31:0] end_time;
      logic        finished;
      logic [15:0] remaining_left;
      logic [31:0] wait_time;
      logic [31:0] turnaround_time;
      logic        last;
   } result_type;
endpackage
`default_nettype wire

// ===== hw/rtl/tlsjf_ram.sv =====
`default_nettype none
module tlsjf_ram #(
   parameter int Width = 48,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/two_level_sjf_slice_scheduler_top.sv =====
`default_nettype none
// Two-level shortest-job-first slice scheduler.
// Input channel req_*: mode 0 appends a job (job_id, burst_time) to a level,
// mode 1 runs one round: level 0 then level 1, each non-empty level gives one
// slice result. Results leave on rsp_* with valid/ready; rsp_last marks the
// final result of an item. An add gives one result; a round gives one or two,
// or one "nothing waiting" result when both levels are empty.
// csr_wr_en/csr_wr_data write slice_length (reset value 20).
// Both job lists live in one RAM (level selects the upper address bit),
// registered read. A round scans the level with one read per cycle to find
// the minimum, then on completion shifts the tail down one entry at a time
// with a read-then-write pair (ST_SHR reads entry i+1, ST_SHW writes entry i).
// One item is handled at a time: req_ready is high only in idle.
// A stalled receiver holds the result register; the sequencer waits.
// Reset (synchronous) empties both levels, clears time and restores the
// slice length; the RAM is not cleared since only counted entries are read.
module two_level_sjf_slice_scheduler_top
   import tlsjf_pkg::*;
#(
   parameter int LEVEL_DEPTH = LevelDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [15:0] req_job_id,
   input  wire logic [15:0] req_burst_time,
   input  wire logic        req_level,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_served_level,
   output logic [15:0]      rsp_job_tag,
   output logic [31:0]      rsp_start_time,
   output logic [31:0]      rsp_end_time,
   output logic             rsp_finished,
   output logic [15:0]      rsp_remaining_left,
   output logic [31:0]      rsp_wait_time,
   output logic [31:0]      rsp_turnaround_time,
   output logic             rsp_last
);
   localparam int IdxW = $clog2(LEVEL_DEPTH);
   localparam int CntW = $clog2(LEVEL_DEPTH + 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(LEVEL_DEPTH);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SEL   = 8'b0000_0010,  // pick next level or finish round
      ST_SCAN  = 8'b0000_0100,  // issue reads, compare returning data
      ST_DEC   = 8'b0000_1000,  // decide finish or slice
      ST_SHR   = 8'b0001_0000,  // shift: read entry i+1
      ST_SHW   = 8'b0010_0000,  // shift: write entry i
      ST_OUT   = 8'b0100_0000,  // wait for result slot
      ST_ADDW  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] slice_ff;
   logic [31:0] time_ff, time_in;
   logic [CntW-1:0] cnt_ff [2];
   logic [CntW-1:0] cnt_in [2];
   logic lvl_ff, lvl_in, any_ff, any_in, nxt_lvl_ff, nxt_lvl_in;
   logic [15:0] id_ff, burst_ff;
   logic [CntW-1:0] ptr_ff, ptr_in;      // scan issue / shift index
   logic [IdxW-1:0] best_ff, best_in;
   entry_type best_e_ff, best_e_in;
   logic have_ff, have_in;               // a read result is in flight
   logic [IdxW-1:0] rd_idx_ff, rd_idx_in;
   logic [1:0] pend_ff, pend_in;         // 0 none, 1 add/nothing, 2 slice
   result_type res_ff, res_in, pres_ff, pres_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic             wr_en;
   logic [IdxW:0]    wr_addr, rd_addr;
   entry_type        wr_data, rd_data;
   logic [IdxW-1:0]  rd_sel;

   tlsjf_ram #(.Width(EntryWidth), .Depth(2 * LEVEL_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
   assign rd_addr = {lvl_ff, rd_sel};

   always_comb begin
      logic [31:0] fin_t;
      logic [CntW-1:0] n;
      state_in = state_ff;
      time_in = time_ff;
      cnt_in = cnt_ff;
      lvl_in = lvl_ff;
      any_in = any_ff;
      nxt_lvl_in = nxt_lvl_ff;
      ptr_in = ptr_ff;
      best_in = best_ff;
      best_e_in = best_e_ff;
      have_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      pend_in = pend_ff;
      pres_in = pres_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = {lvl_ff, ptr_ff[IdxW-1:0]};
      wr_data = rd_data;
      rd_sel = ptr_ff[IdxW-1:0];
      n = cnt_ff[lvl_ff];
      fin_t = time_ff + 32'(best_e_ff.remaining);

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: ;
         ST_SEL: begin
            if (!nxt_lvl_ff && cnt_ff[0] != '0) begin
               lvl_in = 1'b0; nxt_lvl_in = 1'b1;
               ptr_in = '0; state_in = ST_SCAN;
            end else if (cnt_ff[1] != '0) begin
               lvl_in = 1'b1; nxt_lvl_in = 1'b1;
               ptr_in = '0; state_in = ST_SCAN;
            end else if (!any_ff) begin
               pres_in = '0;
               pres_in.status = STATUS_NOTHING;
               pres_in.last = 1'b1;
               pend_in = 2'd1; state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
               pend_in = 2'd0;
            end
         end
         ST_SCAN: begin
            if (ptr_ff < n) begin
               rd_sel = ptr_ff[IdxW-1:0];
               have_in = 1'b1;
               rd_idx_in = ptr_ff[IdxW-1:0];
               ptr_in = ptr_ff + 1'b1;
            end
            if (have_ff) begin
               if (rd_idx_ff == '0 || rd_data.remaining < best_e_ff.remaining) begin
                  best_in = rd_idx_ff;
                  best_e_in = rd_data;
               end
            end else if (ptr_ff >= n) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            pres_in = '0;
            pres_in.status = STATUS_RUN;
            pres_in.served_level = lvl_ff;
            pres_in.job_tag = best_e_ff.id;
            pres_in.start_time = time_ff;
            if ({16'd0, slice_ff} >= {16'd0, best_e_ff.remaining}) begin
               pres_in.end_time = fin_t;
               pres_in.finished = 1'b1;
               pres_in.turnaround_time = fin_t;
               pres_in.wait_time = fin_t - 32'(best_e_ff.burst);
               time_in = fin_t;
               cnt_in[lvl_ff] = n - 1'b1;
               ptr_in = CntW'(best_ff);
               state_in = ST_SHR;
            end else begin
               pres_in.end_time = time_ff + 32'(slice_ff);
               pres_in.remaining_left = best_e_ff.remaining - slice_ff;
               time_in = time_ff + 32'(slice_ff);
               wr_en = 1'b1;
               wr_addr = {lvl_ff, best_ff};
               wr_data = best_e_ff;
               wr_data.remaining = best_e_ff.remaining - slice_ff;
               state_in = ST_OUT;
            end
            any_in = 1'b1;
            pend_in = 2'd2;
         end
         ST_SHR: begin
            // n is already the reduced count
            if (ptr_ff < n) begin
               rd_sel = IdxW'(ptr_ff + 1'b1);
               state_in = ST_SHW;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SHW: begin
            wr_en = 1'b1;
            wr_addr = {lvl_ff, ptr_ff[IdxW-1:0]};
            wr_data = rd_data;
            ptr_in = ptr_ff + 1'b1;
            state_in = ST_SHR;
         end
         ST_ADDW: begin
            pres_in = '0;
            pres_in.served_level = lvl_ff;
            pres_in.job_tag = id_ff;
            pres_in.last = 1'b1;
            if (n >= DepthCnt) begin
               pres_in.status = STATUS_FULL;
            end else begin
               pres_in.status = STATUS_ADDED;
               pres_in.remaining_left = burst_ff;
               wr_en = 1'b1;
               wr_addr = {lvl_ff, n[IdxW-1:0]};
               wr_data = '{id: id_ff, burst: burst_ff, remaining: burst_ff};
               cnt_in[lvl_ff] = n + 1'b1;
            end
            pend_in = 2'd1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               res_in = pres_ff;
               if (pend_ff == 2'd2) begin
                  // a slice result is last unless level 1 still follows
                  res_in.last = lvl_ff || (cnt_in[1] == '0);
               end
               rsp_valid_in = 1'b1;
               pend_in = 2'd0;
               if (pend_ff == 2'd2 && !lvl_ff && cnt_in[1] != '0) begin
                  state_in = ST_SEL;
                  lvl_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_IDLE && req_valid) begin
         lvl_in = req_mode ? 1'b0 : req_level;
         any_in = 1'b0;
         nxt_lvl_in = 1'b0;
         state_in = req_mode ? ST_SEL : ST_ADDW;
      end
   end

   // ST_SEL is entered at the start of a round (nxt_lvl_ff=0) or after level 0
   // was served (nxt_lvl_ff=1); level 1 is then picked whenever it holds jobs.
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slice_ff <= SliceReset;
         time_ff <= '0;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         rsp_valid_ff <= 1'b0;
         have_ff <= 1'b0;
         pend_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         time_ff <= time_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff <= have_in;
         pend_ff <= pend_in;
         if (csr_wr_en) slice_ff <= csr_wr_data;
      end
      lvl_ff <= lvl_in;
      any_ff <= any_in;
      nxt_lvl_ff <= nxt_lvl_in;
      ptr_ff <= ptr_in;
      best_ff <= best_in;
      best_e_ff <= best_e_in;
      rd_idx_ff <= rd_idx_in;
      pres_ff <= pres_in;
      res_ff <= res_in;
      if (state_ff == ST_IDLE && req_valid) begin
         id_ff <= req_job_id;
         burst_ff <= req_burst_time;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = res_ff.status;
   assign rsp_served_level = res_ff.served_level;
   assign rsp_job_tag = res_ff.job_tag;
   assign rsp_start_time = res_ff.start_time;
   assign rsp_end_time = res_ff.end_time;
   assign rsp_finished = res_ff.finished;
   assign rsp_remaining_left = res_ff.remaining_left;
   assign rsp_wait_time = res_ff.wait_time;
   assign rsp_turnaround_time = res_ff.turnaround_time;
   assign rsp_last = res_ff.last;
endmodule
`default_nettype wire

// ===== verif/tb_two_level_sjf_slice_scheduler_top.sv =====
// Testbench for the two-level shortest-job-first slice scheduler.
// A class tracks both job lists, the clock and the slice length, and keeps
// a queue of predicted results. Sender and receiver stall at random.
module tb_two_level_sjf_slice_scheduler_top;
   import tlsjf_pkg::*;

   localparam int Depth = LevelDepthDefault;

   class sched_scoreboard;
      entry_type   jobs[2][$];
      logic [31:0] now;
      logic [15:0] slice_len;
      result_type  pending[$];
      int          errors;

      function void clear();
         jobs[0].delete();
         jobs[1].delete();
         now = 0;
         slice_len = SliceReset;
         pending.delete();
         errors = 0;
      endfunction

      function void serve(int lv);
         result_type r;
         int best;
         logic [15:0] rem;
         r = '0;
         best = 0;
         // Least remaining time wins; strict compare keeps the earliest arrival.
         for (int i = 1; i < jobs[lv].size(); i++)
            if (jobs[lv][i].remaining < jobs[lv][best].remaining) best = i;
         rem = jobs[lv][best].remaining;
         r.status = STATUS_RUN;
         r.served_level = lv[0];
         r.job_tag = jobs[lv][best].id;
         r.start_time = now;
         if (slice_len >= rem) begin
            now = now + rem;
            r.end_time = now;
            r.finished = 1'b1;
            r.turnaround_time = now;
            r.wait_time = now - 32'(jobs[lv][best].burst);
            jobs[lv].delete(best);
         end else begin
            jobs[lv][best].remaining = rem - slice_len;
            now = now + slice_len;
            r.end_time = now;
            r.remaining_left = rem - slice_len;
         end
         pending.push_back(r);
      endfunction

      // Notes one accepted item and queues the results it causes.
      function void note_item(logic mode, logic [15:0] id, logic [15:0] burst,
                              logic lv);
         result_type r;
         entry_type e;
         int lvi;
         r = '0;
         lvi = lv;
         if (mode == 1'b0) begin
            r.served_level = lv;
            r.job_tag = id;
            r.last = 1'b1;
            if (jobs[lvi].size() >= Depth) begin
               r.status = STATUS_FULL;
            end else begin
               e.id = id;
               e.burst = burst;
               e.remaining = burst;
               jobs[lvi].push_back(e);
               r.status = STATUS_ADDED;
               r.remaining_left = burst;
            end
            pending.push_back(r);
         end else begin
            if (jobs[0].size() == 0 && jobs[1].size() == 0) begin
               r.status = STATUS_NOTHING;
               pending.push_back(r);
            end else begin
               for (int l = 0; l < 2; l++)
                  if (jobs[l].size() != 0) serve(l);
            end
            pending[$].last = 1'b1;
         end
      endfunction

      function void check_result(result_type got);
         result_type x;
         if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         x = pending.pop_front();
         if (got.status != x.status) begin
            $error("status exp %0d got %0d", x.status, got.status); errors++;
         end
         if (got.served_level != x.served_level) begin
            $error("served_level exp %0d got %0d", x.served_level, got.served_level);
            errors++;
         end
         if (got.job_tag != x.job_tag) begin
            $error("job_tag exp %0d got %0d", x.job_tag, got.job_tag); errors++;
         end
         if (got.start_time != x.start_time) begin
            $error("start_time exp %0d got %0d", x.start_time, got.start_time);
            errors++;
         end
         if (got.end_time != x.end_time) begin
            $error("end_time exp %0d got %0d", x.end_time, got.end_time); errors++;
         end
         if (got.finished != x.finished) begin
            $error("finished exp %0d got %0d", x.finished, got.finished); errors++;
         end
         if (got.remaining_left != x.remaining_left) begin
            $error("remaining_left exp %0d got %0d", x.remaining_left,
                   got.remaining_left);
            errors++;
         end
         if (got.wait_time != x.wait_time) begin
            $error("wait_time exp %0d got %0d", x.wait_time, got.wait_time);
            errors++;
         end
         if (got.turnaround_time != x.turnaround_time) begin
            $error("turnaround_time exp %0d got %0d", x.turnaround_time,
                   got.turnaround_time);
            errors++;
         end
         if (got.last != x.last) begin
            $error("last exp %0d got %0d", x.last, got.last); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [15:0] req_job_id = '0;
   logic [15:0] req_burst_time = '0;
   logic        req_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_served_level;
   logic [15:0] rsp_job_tag;
   logic [31:0] rsp_start_time;
   logic [31:0] rsp_end_time;
   logic        rsp_finished;
   logic [15:0] rsp_remaining_left;
   logic [31:0] rsp_wait_time;
   logic [31:0] rsp_turnaround_time;
   logic        rsp_last;

   sched_scoreboard sb;
   int idle_cycles;   // cycles with no handshake on either channel

   always #5 clock = ~clock;

   two_level_sjf_slice_scheduler_top DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_job_id(req_job_id), .req_burst_time(req_burst_time),
      .req_level(req_level),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_served_level(rsp_served_level), .rsp_job_tag(rsp_job_tag),
      .rsp_start_time(rsp_start_time), .rsp_end_time(rsp_end_time),
      .rsp_finished(rsp_finished), .rsp_remaining_left(rsp_remaining_left),
      .rsp_wait_time(rsp_wait_time), .rsp_turnaround_time(rsp_turnaround_time),
      .rsp_last(rsp_last)
   );

   // Receiver: random stall per result, check at the accepting edge.
   initial begin
      result_type got;
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.status = status_type'(rsp_status);
         got.served_level = rsp_served_level;
         got.job_tag = rsp_job_tag;
         got.start_time = rsp_start_time;
         got.end_time = rsp_end_time;
         got.finished = rsp_finished;
         got.remaining_left = rsp_remaining_left;
         got.wait_time = rsp_wait_time;
         got.turnaround_time = rsp_turnaround_time;
         got.last = rsp_last;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   // Watchdog: a full round of two deep levels plus stalls stays far below.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb_two_level_sjf_slice_scheduler_top: done, errors");
         $finish;
      end
   end

   // One item: random hold-off, then valid until accepted. This task drops valid
   // only during a hold-off, so back-to-back items keep it high.
   task automatic send_item(logic mode, logic [15:0] id, logic [15:0] burst,
                            logic lv);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 9) < 3) gap = 0;  // back-to-back stretches
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_job_id <= id;
      req_burst_time <= burst;
      req_level <= lv;
      do @(posedge clock); while (!req_ready);
      sb.note_item(mode, id, burst, lv);
      @(negedge clock);
   endtask

   task automatic add_job(logic [15:0] id, logic [15:0] burst, logic lv);
      send_item(1'b0, id, burst, lv);
   endtask

   task automatic run_round();
      send_item(1'b1, 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   // Slice length is written only with nothing outstanding.
   task automatic set_slice(logic [15:0] val);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.slice_len = val;
   endtask

   // Drain everything queued in the lists.
   task automatic drain_lists();
      while (sb.jobs[0].size() + sb.jobs[1].size() != 0) run_round();
   endtask

   function automatic logic [15:0] pick_burst(int slen);
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 3 * slen + 2));
      endcase
   endfunction

   initial begin
      logic [15:0] slices[6];
      int slen;
      sb = new();
      sb.clear();
      slices = '{16'd20, 16'd1, 16'hFFFF, 16'd0, 16'd7, 16'd300};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty round, extremes, ties, zero burst, full level.
      run_round();
      add_job(16'h0000, 16'd0, 1'b0);
      add_job(16'hFFFF, 16'hFFFF, 1'b1);
      add_job(16'h1234, 16'd5, 1'b0);
      add_job(16'h1235, 16'd5, 1'b0);
      add_job(16'h00AA, 16'd40, 1'b1);
      repeat (5) run_round();
      for (int i = 0; i < Depth + 2; i++) add_job(16'(i), 16'(i % 3), 1'b0);
      add_job(16'h7777, 16'd1, 1'b1);
      drain_lists();
      run_round();

      // Random phases across slice settings, including zero and maximum.
      for (int p = 0; p < 12; p++) begin
         slen = slices[p % 6];
         if (p == 0 || p == 6) slen = $urandom_range(1, 65535);
         set_slice(16'(slen));
         for (int k = 0; k < 150; k++) begin
            if ($urandom_range(0, 99) < 55)
               add_job(16'($urandom), pick_burst(slen > 0 ? slen : 4),
                       1'($urandom));
            else
               run_round();
         end
         // Occasionally add Depth+1 jobs at random levels so rejections can show up.
         if (p % 4 == 3)
            for (int i = 0; i < Depth + 1; i++)
               add_job(16'($urandom), pick_burst(4), 1'($urandom));
         if (p % 3 == 2) begin
            set_slice(16'hFFFF);
            drain_lists();
         end
      end
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_two_level_sjf_slice_scheduler_top: done, clean");
      else
         $display("tb_two_level_sjf_slice_scheduler_top: done, errors");
      $finish;
   end
endmodule
